// ----- sv/mba_pkg.sv -----
// Shared types and constants for the multi-sensor block averager.
// Used by the controller, datapath, divider, top level and checker.
package mba_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int SUM_W     = 32;
   localparam int THR_W     = 10;
   localparam int GRP_W     = 2;
   localparam int GRP_NUM   = 4;
   localparam int AXIS_GRPS = 3;
   localparam int DIV_STEPS = SUM_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(100);

   localparam logic [GRP_W-1:0] GRP_LOWG = 2'd0;
   localparam logic [GRP_W-1:0] GRP_TEMP = 2'd3;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [SAMPLE_W-1:0] AVG_POS_MAX = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0] AVG_NEG_MAX = 16'h8000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GROUP,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT,
      ST_EMIT_WAIT
   } mba_state_type;

   typedef struct packed {
      logic accumulate;
      logic run_start;
      logic div_start;
      logic store_avg;
      logic mark_stale;
      logic emit;
      logic next_group;
   } mba_cmd_type;

   typedef struct packed {
      logic trigger;
      logic count_zero;
      logic axis_last;
      logic grp_last;
      logic div_done;
      logic rsp_busy;
   } mba_status_type;

endpackage

// ----- sv/mba_divider.sv -----
// Serial restoring divider: signed 32-bit sum by unsigned count, one quotient bit a cycle.
// Result truncates toward zero and saturates to 16 bits. Depends on mba_pkg.
module mba_divider import mba_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [SUM_W-1:0]            dividend,
   input  logic [COUNT_WIDTH-1:0]      divisor,
   output logic                        done,
   output logic [SAMPLE_W-1:0]         quotient
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   neg_ff, neg_in;
   logic [SUM_W-1:0]       quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] div_ff, div_in;

   logic [COUNT_WIDTH:0]   shifted;
   logic [COUNT_WIDTH:0]   diff;
   logic                   fits;
   logic [SUM_W-1:0]       quo_neg;

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign fits    = shifted >= {1'b0, div_ff};
   assign diff    = shifted - {1'b0, div_ff};
   assign quo_neg = ~quo_ff + SUM_W'(1);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   always_comb begin
      if (neg_ff) begin
         quotient = (quo_ff > SUM_W'(32768)) ? AVG_NEG_MAX : quo_neg[SAMPLE_W-1:0];
      end else begin
         quotient = (quo_ff > SUM_W'(32767)) ? AVG_POS_MAX : quo_ff[SAMPLE_W-1:0];
      end
   end

   assign done = done_ff;

endmodule

// ----- sv/mba_datapath.sv -----
// Datapath: group sums and counts, held averages, threshold register, result register.
// Driven by mba_ctrl commands; instantiates mba_divider. Depends on mba_pkg.
module mba_datapath import mba_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mba_cmd_type                cmd,
   output mba_status_type             status,
   input  logic [GRP_W-1:0]           req_sensor_group,
   input  logic signed [SAMPLE_W-1:0] req_sample_x,
   input  logic signed [SAMPLE_W-1:0] req_sample_y,
   input  logic signed [SAMPLE_W-1:0] req_sample_z,
   input  logic                       csr_valid,
   input  logic [THR_W-1:0]           csr_sample_threshold,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [GRP_W-1:0]           rsp_out_group,
   output logic signed [SAMPLE_W-1:0] rsp_avg_x,
   output logic signed [SAMPLE_W-1:0] rsp_avg_y,
   output logic signed [SAMPLE_W-1:0] rsp_avg_z,
   output logic                       rsp_fresh,
   output logic                       rsp_last_of_run
);

   localparam int CmpWidth = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;
   localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

   logic [SUM_W-1:0]       sum_x_ff [GRP_NUM];
   logic [SUM_W-1:0]       sum_x_in [GRP_NUM];
   logic [SUM_W-1:0]       sum_y_ff [AXIS_GRPS];
   logic [SUM_W-1:0]       sum_y_in [AXIS_GRPS];
   logic [SUM_W-1:0]       sum_z_ff [AXIS_GRPS];
   logic [SUM_W-1:0]       sum_z_in [AXIS_GRPS];
   logic [COUNT_WIDTH-1:0] count_ff [GRP_NUM];
   logic [COUNT_WIDTH-1:0] count_in [GRP_NUM];
   logic [SAMPLE_W-1:0]    held_x_ff [GRP_NUM];
   logic [SAMPLE_W-1:0]    held_x_in [GRP_NUM];
   logic [SAMPLE_W-1:0]    held_y_ff [AXIS_GRPS];
   logic [SAMPLE_W-1:0]    held_y_in [AXIS_GRPS];
   logic [SAMPLE_W-1:0]    held_z_ff [AXIS_GRPS];
   logic [SAMPLE_W-1:0]    held_z_in [AXIS_GRPS];

   logic [THR_W-1:0]       thr_ff, thr_in;
   logic [GRP_W-1:0]       grp_ff, grp_in;
   logic [1:0]             axis_ff, axis_in;
   logic                   fresh_ff, fresh_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [GRP_W-1:0]       rsp_group_ff, rsp_group_in;
   logic [SAMPLE_W-1:0]    rsp_x_ff, rsp_x_in;
   logic [SAMPLE_W-1:0]    rsp_y_ff, rsp_y_in;
   logic [SAMPLE_W-1:0]    rsp_z_ff, rsp_z_in;
   logic                   rsp_fresh_ff, rsp_fresh_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [GRP_W-1:0]       sel_grp;
   logic                   axis_last;
   logic [THR_W-1:0]       thr_eff;
   logic [SUM_W-1:0]       dividend;
   logic                   div_done;
   logic [SAMPLE_W-1:0]    quotient;

   mba_divider #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(dividend),
      .divisor (count_ff[grp_ff]),
      .done    (div_done),
      .quotient(quotient)
   );

   assign sel_grp   = cmd.accumulate ? req_sensor_group : grp_ff;
   assign axis_last = (grp_ff == GRP_TEMP) ? (axis_ff == AXIS_X) : (axis_ff == AXIS_Z);
   assign thr_eff   = (thr_ff == '0) ? THR_W'(1) : thr_ff;

   always_comb begin
      dividend = '0;
      case (axis_ff)
         AXIS_X: dividend = sum_x_ff[grp_ff];
         AXIS_Y: begin
            if (grp_ff != GRP_TEMP) dividend = sum_y_ff[grp_ff];
         end
         AXIS_Z: begin
            if (grp_ff != GRP_TEMP) dividend = sum_z_ff[grp_ff];
         end
         default: dividend = '0;
      endcase
   end

   always_comb begin
      status.trigger    = CmpWidth'(count_ff[GRP_LOWG]) >= CmpWidth'(thr_eff);
      status.count_zero = (count_ff[grp_ff] == '0);
      status.axis_last  = axis_last;
      status.grp_last   = (grp_ff == GRP_TEMP);
      status.div_done   = div_done;
      status.rsp_busy   = rsp_valid_ff;
   end

   always_comb begin
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      sum_z_in     = sum_z_ff;
      count_in     = count_ff;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      held_z_in    = held_z_ff;
      thr_in       = csr_valid ? csr_sample_threshold : thr_ff;
      grp_in       = grp_ff;
      axis_in      = axis_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_group_in = rsp_group_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_fresh_in = rsp_fresh_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.accumulate && (count_ff[sel_grp] != CountMax)) begin
         sum_x_in[sel_grp] = sum_x_ff[sel_grp] + SUM_W'(req_sample_x);
         if (sel_grp != GRP_TEMP) begin
            sum_y_in[sel_grp] = sum_y_ff[sel_grp] + SUM_W'(req_sample_y);
            sum_z_in[sel_grp] = sum_z_ff[sel_grp] + SUM_W'(req_sample_z);
         end
         count_in[sel_grp] = count_ff[sel_grp] + COUNT_WIDTH'(1);
      end

      if (cmd.run_start) begin
         grp_in  = GRP_LOWG;
         axis_in = AXIS_X;
      end

      if (cmd.store_avg) begin
         case (axis_ff)
            AXIS_X: begin
               held_x_in[grp_ff] = quotient;
               sum_x_in[grp_ff]  = '0;
            end
            AXIS_Y: begin
               if (grp_ff != GRP_TEMP) begin
                  held_y_in[grp_ff] = quotient;
                  sum_y_in[grp_ff]  = '0;
               end
            end
            AXIS_Z: begin
               if (grp_ff != GRP_TEMP) begin
                  held_z_in[grp_ff] = quotient;
                  sum_z_in[grp_ff]  = '0;
               end
            end
            default: axis_in = axis_ff;
         endcase
         if (axis_last) begin
            count_in[grp_ff] = '0;
            fresh_in         = 1'b1;
         end else begin
            axis_in = axis_ff + 2'd1;
         end
      end

      if (cmd.mark_stale) fresh_in = 1'b0;

      if (cmd.next_group) begin
         grp_in  = grp_ff + GRP_W'(1);
         axis_in = AXIS_X;
      end

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_group_in = grp_ff;
         rsp_x_in     = held_x_ff[grp_ff];
         rsp_y_in     = '0;
         rsp_z_in     = '0;
         if (grp_ff != GRP_TEMP) begin
            rsp_y_in = held_y_ff[grp_ff];
            rsp_z_in = held_z_ff[grp_ff];
         end
         rsp_fresh_in = fresh_ff;
         rsp_last_in  = (grp_ff == GRP_TEMP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < GRP_NUM; i++) begin
            sum_x_ff[i]  <= '0;
            count_ff[i]  <= '0;
            held_x_ff[i] <= '0;
         end
         for (int i = 0; i < AXIS_GRPS; i++) begin
            sum_y_ff[i]  <= '0;
            sum_z_ff[i]  <= '0;
            held_y_ff[i] <= '0;
            held_z_ff[i] <= '0;
         end
         thr_ff       <= THR_RESET;
         grp_ff       <= GRP_LOWG;
         axis_ff      <= AXIS_X;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_z_ff     <= sum_z_in;
         count_ff     <= count_in;
         held_x_ff    <= held_x_in;
         held_y_ff    <= held_y_in;
         held_z_ff    <= held_z_in;
         thr_ff       <= thr_in;
         grp_ff       <= grp_in;
         axis_ff      <= axis_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_group_ff <= rsp_group_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
      rsp_fresh_ff <= rsp_fresh_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_group   = rsp_group_ff;
   assign rsp_avg_x       = rsp_x_ff;
   assign rsp_avg_y       = rsp_y_ff;
   assign rsp_avg_z       = rsp_z_ff;
   assign rsp_fresh       = rsp_fresh_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

// ----- sv/mba_ctrl.sv -----
// Controller state machine: accepts requests, walks groups and axes, sequences divides and results.
// Talks to mba_datapath by command and status structs. Depends on mba_pkg.
module mba_ctrl import mba_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  mba_status_type status,
   output mba_cmd_type    cmd
);

   mba_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accumulate = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.trigger) begin
               cmd.run_start = 1'b1;
               state_in      = ST_GROUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_GROUP: begin
            if (status.count_zero) begin
               cmd.mark_stale = 1'b1;
               state_in       = ST_EMIT;
            end else begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.store_avg = 1'b1;
               state_in      = status.axis_last ? ST_EMIT : ST_DIV_START;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (!status.rsp_busy) begin
               if (status.grp_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_group = 1'b1;
                  state_in       = ST_GROUP;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- sv/multi_sensor_block_averager_top.sv -----
// Top level of the multi-sensor block averager: controller plus datapath.
// Depends on mba_pkg, mba_ctrl, mba_datapath, mba_divider.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------------
//   req      | req_valid/stall    | sensor_group, sample_x/y/z
//   rsp      | rsp_valid/stall    | out_group, avg_x/y/z, fresh, last_of_run
//   csr      | csr_valid/ready    | sample_threshold (ready always high)
//
// A request that does not trigger output goes through acceptance and the threshold check.
// A triggering request adds a run of up to ten serial divides, each of 32 quotient
// steps plus start and done, and for each result the group, emit and emit-wait states.
// req_stall is high for the whole run; rsp_stall holds the result register and the run.
// Reset is synchronous and clears sums, counts, held averages and the threshold to 100.
module multi_sensor_block_averager_top import mba_pkg::*; #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [GRP_W-1:0]           req_sensor_group,
   input  logic signed [SAMPLE_W-1:0] req_sample_x,
   input  logic signed [SAMPLE_W-1:0] req_sample_y,
   input  logic signed [SAMPLE_W-1:0] req_sample_z,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [GRP_W-1:0]           rsp_out_group,
   output logic signed [SAMPLE_W-1:0] rsp_avg_x,
   output logic signed [SAMPLE_W-1:0] rsp_avg_y,
   output logic signed [SAMPLE_W-1:0] rsp_avg_z,
   output logic                       rsp_fresh,
   output logic                       rsp_last_of_run,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [THR_W-1:0]           csr_sample_threshold
);

   mba_cmd_type    cmd;
   mba_status_type status;

   assign csr_ready = 1'b1;

   mba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   mba_datapath #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_sensor_group    (req_sensor_group),
      .req_sample_x        (req_sample_x),
      .req_sample_y        (req_sample_y),
      .req_sample_z        (req_sample_z),
      .csr_valid           (csr_valid),
      .csr_sample_threshold(csr_sample_threshold),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_group       (rsp_out_group),
      .rsp_avg_x           (rsp_avg_x),
      .rsp_avg_y           (rsp_avg_y),
      .rsp_avg_z           (rsp_avg_z),
      .rsp_fresh           (rsp_fresh),
      .rsp_last_of_run     (rsp_last_of_run)
   );

endmodule

// ----- sv/mba_checker.sv -----
// Port-level checker for the multi-sensor block averager, bound to the top level.
// Depends on mba_pkg.
module mba_checker import mba_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [GRP_W-1:0]           rsp_out_group,
   input logic signed [SAMPLE_W-1:0] rsp_avg_x,
   input logic signed [SAMPLE_W-1:0] rsp_avg_y,
   input logic signed [SAMPLE_W-1:0] rsp_avg_z,
   input logic                       rsp_fresh,
   input logic                       rsp_last_of_run
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_group) && $stable(rsp_avg_x)
         && $stable(rsp_avg_y) && $stable(rsp_avg_z) && $stable(rsp_fresh)
         && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   a_last_is_temp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_of_run == (rsp_out_group == GRP_TEMP)))
      else $error("last_of_run not on temperature result");

   a_temp_yz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_group == GRP_TEMP) |-> (rsp_avg_y == '0) && (rsp_avg_z == '0))
      else $error("temperature result has nonzero y or z");

   // no request taken while a run is presenting results
   a_no_req_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted during result run");

endmodule

bind multi_sensor_block_averager_top mba_checker u_mba_checker (.*);

// ----- tb/multi_sensor_block_averager_top_tb.sv -----
// Self-checking testbench for multi_sensor_block_averager_top.
// Predicts the per-group block averages of each request and checks every result.
// Depends on mba_pkg and the multi_sensor_block_averager_top RTL.
`timescale 1ns / 100ps

module multi_sensor_block_averager_top_tb;
   import mba_pkg::*;

   localparam int COUNT_WIDTH  = 16;
   localparam int COUNT_MAX    = (1 << COUNT_WIDTH) - 1;
   localparam int SETTLE_CYC   = 10;
   localparam int END_CYC      = 40;
   localparam int STALL_LIMIT  = 4000;
   localparam int ERR_PRINT    = 100;

   localparam logic [GRP_W-1:0] GRP_HIGHG = 2'd1;
   localparam logic [GRP_W-1:0] GRP_GYRO  = 2'd2;

   typedef struct packed {
      logic [GRP_W-1:0]           grp;
      logic signed [SAMPLE_W-1:0] x;
      logic signed [SAMPLE_W-1:0] y;
      logic signed [SAMPLE_W-1:0] z;
      logic                       fresh;
      logic                       last;
   } avg_result_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [GRP_W-1:0]           req_sensor_group;
   logic signed [SAMPLE_W-1:0] req_sample_x;
   logic signed [SAMPLE_W-1:0] req_sample_y;
   logic signed [SAMPLE_W-1:0] req_sample_z;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [GRP_W-1:0]           rsp_out_group;
   logic signed [SAMPLE_W-1:0] rsp_avg_x;
   logic signed [SAMPLE_W-1:0] rsp_avg_y;
   logic signed [SAMPLE_W-1:0] rsp_avg_z;
   logic                       rsp_fresh;
   logic                       rsp_last_of_run;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [THR_W-1:0]           csr_sample_threshold;

   // predictor state
   logic [SUM_W-1:0]    axis_sum [9];
   logic [SUM_W-1:0]    temp_total;
   int unsigned         group_count [GRP_NUM];
   logic [SAMPLE_W-1:0] held_avg [10];
   logic [THR_W-1:0]    threshold_model;

   avg_result_type avg_expected [$];
   avg_result_type want_rsp;
   int             error_count;
   int             idle_cycles;
   int             send_idle_pct;
   int             recv_idle_pct;

   multi_sensor_block_averager_top #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sensor_group     (req_sensor_group),
      .req_sample_x         (req_sample_x),
      .req_sample_y         (req_sample_y),
      .req_sample_z         (req_sample_z),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_group        (rsp_out_group),
      .rsp_avg_x            (rsp_avg_x),
      .rsp_avg_y            (rsp_avg_y),
      .rsp_avg_z            (rsp_avg_z),
      .rsp_fresh            (rsp_fresh),
      .rsp_last_of_run      (rsp_last_of_run),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_sample_threshold (csr_sample_threshold)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (error_count < ERR_PRINT) begin
         $display("ERROR @%0t: %s", $time, what);
      end
      error_count++;
   endtask

   // truncating divide, clamped to the 16-bit signed range
   function automatic logic [SAMPLE_W-1:0] block_mean(input logic [SUM_W-1:0] total,
                                                      input int unsigned n);
      longint q;
      q = longint'($signed(total)) / longint'(n);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[SAMPLE_W-1:0];
   endfunction

   task automatic accumulate_sample(input logic [GRP_W-1:0] grp,
                                    input logic signed [SAMPLE_W-1:0] sx,
                                    input logic signed [SAMPLE_W-1:0] sy,
                                    input logic signed [SAMPLE_W-1:0] sz);
      int unsigned    thr;
      int             g;
      int             a;
      avg_result_type r;
      if (group_count[grp] < COUNT_MAX) begin
         if (grp != GRP_TEMP) begin
            axis_sum[grp*3+0] += 32'(sx);
            axis_sum[grp*3+1] += 32'(sy);
            axis_sum[grp*3+2] += 32'(sz);
         end else begin
            temp_total += 32'(sx);
         end
         group_count[grp]++;
      end
      thr = (threshold_model == '0) ? 1 : threshold_model;
      if (group_count[GRP_LOWG] < thr) return;
      for (g = 0; g < GRP_NUM; g++) begin
         r.fresh = (group_count[g] > 0);
         if (r.fresh) begin
            if (g < AXIS_GRPS) begin
               for (a = 0; a < 3; a++) begin
                  held_avg[g*3+a] = block_mean(axis_sum[g*3+a], group_count[g]);
                  axis_sum[g*3+a] = '0;
               end
            end else begin
               held_avg[9] = block_mean(temp_total, group_count[g]);
               temp_total = '0;
            end
            group_count[g] = 0;
         end
         r.grp = GRP_W'(g);
         if (g < AXIS_GRPS) begin
            r.x = held_avg[g*3+0];
            r.y = held_avg[g*3+1];
            r.z = held_avg[g*3+2];
         end else begin
            r.x = held_avg[9];
            r.y = '0;
            r.z = '0;
         end
         r.last = (g == GRP_NUM - 1);
         avg_expected.push_back(r);
      end
   endtask

   task automatic send_sample(input logic [GRP_W-1:0] grp,
                              input logic signed [SAMPLE_W-1:0] sx,
                              input logic signed [SAMPLE_W-1:0] sy,
                              input logic signed [SAMPLE_W-1:0] sz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sensor_group <= grp;
      req_sample_x     <= sx;
      req_sample_y     <= sy;
      req_sample_z     <= sz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accumulate_sample(grp, sx, sy, sz);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (avg_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      wait_drained();
      csr_valid            <= 1'b1;
      csr_sample_threshold <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      threshold_model = value;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return '0;
         3:       return SAMPLE_W'($signed($urandom_range(16)) - 8);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [GRP_W-1:0] rand_group();
      if ($urandom_range(99) < 45) return GRP_LOWG;
      return GRP_W'($urandom_range(GRP_TEMP, GRP_HIGHG));
   endfunction

   function automatic logic [THR_W-1:0] rand_threshold();
      int r;
      r = $urandom_range(99);
      if (r < 8) return '0;
      if (r < 14) return '1;
      if (r < 80) return THR_W'($urandom_range(4, 1));
      return THR_W'($urandom_range(20, 5));
   endfunction

   // Reset threshold of 100: 99 low-g requests stay below it, the hundredth triggers.
   task automatic test_reset_threshold();
      int i;
      send_idle_pct = 12;
      recv_idle_pct = 75;
      for (i = 0; i < 99; i++) begin
         send_sample(GRP_LOWG, rand_sample(), rand_sample(), rand_sample());
      end
      for (i = 0; i < 6; i++) begin
         send_sample(GRP_GYRO, 16'sh7FFF, 16'sh8000, rand_sample());
      end
      send_sample(GRP_TEMP, rand_sample(), rand_sample(), rand_sample());
      send_sample(GRP_LOWG, rand_sample(), rand_sample(), rand_sample());
      wait_drained();
   endtask

   task automatic test_directed();
      send_idle_pct = 12;
      recv_idle_pct = 75;
      write_threshold(THR_W'(1));
      send_sample(GRP_LOWG, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_sample(GRP_HIGHG, 16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(GRP_GYRO, 16'sh7FFF, 16'sh8000, 16'sh0000);
      send_sample(GRP_TEMP, 16'sh8000, 16'sh7FFF, -16'sd1);
      send_sample(GRP_LOWG, 16'sh8000, 16'sh8000, 16'sh8000);
      // held averages repeat with fresh low
      send_sample(GRP_LOWG, 16'sh0000, 16'sh0000, 16'sh0000);
      // zero threshold behaves as one
      write_threshold('0);
      send_sample(GRP_LOWG, 16'sd1, -16'sd1, 16'sd5);
      // truncation toward zero
      write_threshold(THR_W'(3));
      send_sample(GRP_TEMP, 16'sd100, 16'sh7FFF, 16'sh8000);
      send_sample(GRP_LOWG, -16'sd1, 16'sd1, 16'sd7);
      send_sample(GRP_HIGHG, 16'sd5, -16'sd5, 16'sd2);
      send_sample(GRP_TEMP, -16'sd101, 16'sd0, 16'sd0);
      send_sample(GRP_LOWG, -16'sd1, 16'sd1, 16'sd7);
      send_sample(GRP_LOWG, 16'sd0, -16'sd1, -16'sd7);
      wait_drained();
   endtask

   // Threshold dropped below the pending low-g count: next request of any group triggers.
   task automatic test_lowered_threshold();
      int i;
      send_idle_pct = 12;
      recv_idle_pct = 75;
      write_threshold('1);
      for (i = 0; i < 4; i++) begin
         send_sample(GRP_LOWG, rand_sample(), rand_sample(), rand_sample());
      end
      send_sample(GRP_HIGHG, rand_sample(), rand_sample(), rand_sample());
      write_threshold(THR_W'(3));
      send_sample(GRP_GYRO, rand_sample(), rand_sample(), rand_sample());
      wait_drained();
   endtask

   task automatic test_random(input int n, input int s_idle, input int r_idle);
      int i;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (i = 0; i < n; i++) begin
         if (i % 40 == 0) write_threshold(rand_threshold());
         send_sample(rand_group(), rand_sample(), rand_sample(), rand_sample());
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (avg_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected result group %0d", rsp_out_group));
         end else begin
            want_rsp = avg_expected.pop_front();
            if (rsp_out_group !== want_rsp.grp)
               report_mismatch($sformatf("out_group %0d, want %0d", rsp_out_group,
                                         want_rsp.grp));
            if (rsp_avg_x !== want_rsp.x)
               report_mismatch($sformatf("group %0d avg_x %0d, want %0d", want_rsp.grp,
                                         rsp_avg_x, want_rsp.x));
            if (rsp_avg_y !== want_rsp.y)
               report_mismatch($sformatf("group %0d avg_y %0d, want %0d", want_rsp.grp,
                                         rsp_avg_y, want_rsp.y));
            if (rsp_avg_z !== want_rsp.z)
               report_mismatch($sformatf("group %0d avg_z %0d, want %0d", want_rsp.grp,
                                         rsp_avg_z, want_rsp.z));
            if (rsp_fresh !== want_rsp.fresh)
               report_mismatch($sformatf("group %0d fresh %b, want %b", want_rsp.grp,
                                         rsp_fresh, want_rsp.fresh));
            if (rsp_last_of_run !== want_rsp.last)
               report_mismatch($sformatf("group %0d last_of_run %b, want %b", want_rsp.grp,
                                         rsp_last_of_run, want_rsp.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
          (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("ERROR @%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("multi_sensor_block_averager_top_tb: FAIL");
         $finish;
      end
   end

   initial begin
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_sensor_group     <= '0;
      req_sample_x         <= '0;
      req_sample_y         <= '0;
      req_sample_z         <= '0;
      rsp_stall            <= 1'b0;
      csr_valid            <= 1'b0;
      csr_sample_threshold <= '0;
      error_count     = 0;
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      threshold_model = THR_RESET;
      temp_total      = '0;
      for (int i = 0; i < 9; i++) axis_sum[i] = '0;
      for (int i = 0; i < GRP_NUM; i++) group_count[i] = 0;
      for (int i = 0; i < 10; i++) held_avg[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_threshold();
      test_directed();
      test_lowered_threshold();
      test_random(68, 12, 75);
      test_random(68, 75, 12);
      test_random(68, 0, 0);

      repeat (END_CYC) @(posedge clock);
      if (avg_expected.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", avg_expected.size()));
      end
      if (error_count == 0) begin
         $display("multi_sensor_block_averager_top_tb: PASS");
      end else begin
         $display("multi_sensor_block_averager_top_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/mba_pkg.sv
sv/mba_divider.sv
sv/mba_datapath.sv
sv/mba_ctrl.sv
sv/multi_sensor_block_averager_top.sv
sv/mba_checker.sv
tb/multi_sensor_block_averager_top_tb.sv
